[src/awl_pkg.sv]
// Shared types, constants and the sequencer microcode for the antialiased line generator.
package awl_pkg;

  localparam int COORD_BITS    = 12;
  localparam int PIX_BITS      = COORD_BITS + 1;
  localparam int DEF_FRAC_BITS = 16;
  localparam int COV_BITS      = 8;

  localparam logic [COV_BITS-1:0] COV_HALF = 8'd127;
  localparam logic [COV_BITS-1:0] COV_NONE = 8'd0;
  localparam logic [COV_BITS-1:0] COV_FULL = 8'd255;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_TICK  = 1'b1
  } kind_t;

  typedef struct packed {
    logic                  kind;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
  } in_item_t;

  typedef struct packed {
    logic [PIX_BITS-1:0] pixel_x;
    logic [PIX_BITS-1:0] pixel_y;
    logic [COV_BITS-1:0] coverage;
    logic                last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SWAP,
    ST_ORDER,
    ST_PREP,
    ST_DIV,
    ST_SLOPE,
    ST_END_A0,
    ST_END_A1,
    ST_END_B0,
    ST_END_B1,
    ST_COL0,
    ST_COL1
  } step_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SWAP,
    OP_ORDER,
    OP_PREP,
    OP_DIV,
    OP_SLOPE,
    OP_ADVANCE
  } op_t;

  typedef enum logic [2:0] {
    PIX_NONE,
    PIX_A0,
    PIX_A1,
    PIX_B0,
    PIX_B1,
    PIX_C0,
    PIX_C1
  } pix_t;

  typedef enum logic [1:0] {
    COND_NEXT,
    COND_GOTO,
    COND_LOOP,
    COND_DISPATCH
  } cond_t;

  typedef struct packed {
    op_t   op;
    pix_t  pix;
    logic  emit;
    logic  take;
    cond_t cond;
    step_t target;
  } ucode_t;

  typedef struct packed {
    op_t  op;
    pix_t pix;
    logic emit;
    logic take;
    logic fire;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic in_tick;
    logic active;
    logic div_done;
    logic out_free;
  } seq_stat_t;

  // The control store: one word per step.
  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    w.op     = OP_NONE;
    w.pix    = PIX_NONE;
    w.emit   = 1'b0;
    w.take   = 1'b0;
    w.cond   = COND_NEXT;
    w.target = ST_IDLE;
    unique case (s)
      ST_IDLE: begin
        w.take = 1'b1;
        w.cond = COND_DISPATCH;
      end
      ST_SWAP:  w.op = OP_SWAP;
      ST_ORDER: w.op = OP_ORDER;
      ST_PREP:  w.op = OP_PREP;
      ST_DIV: begin
        w.op   = OP_DIV;
        w.cond = COND_LOOP;
      end
      ST_SLOPE: w.op = OP_SLOPE;
      ST_END_A0: begin
        w.emit = 1'b1;
        w.pix  = PIX_A0;
      end
      ST_END_A1: begin
        w.emit = 1'b1;
        w.pix  = PIX_A1;
      end
      ST_END_B0: begin
        w.emit = 1'b1;
        w.pix  = PIX_B0;
      end
      ST_END_B1: begin
        w.emit = 1'b1;
        w.pix  = PIX_B1;
        w.cond = COND_GOTO;
      end
      ST_COL0: begin
        w.emit = 1'b1;
        w.pix  = PIX_C0;
      end
      ST_COL1: begin
        w.emit = 1'b1;
        w.pix  = PIX_C1;
        w.op   = OP_ADVANCE;
        w.cond = COND_GOTO;
      end
      default: begin
        w.cond = COND_GOTO;
      end
    endcase
    return w;
  endfunction

endpackage

[src/antialiased_line_generator_top.sv]
// Top level of the antialiased line generator: datapath, output register and sequencer.
//
// This block draws Wu antialiased lines. A start item carries two endpoints; the block
// decides whether the line is steep, orders the endpoints along the major axis, divides
// to get a signed gradient with FRAC_BITS fraction bits (truncated toward zero, exactly
// 1.0 for a zero-length line) and then delivers four items for the two endpoints: each
// endpoint at coverage 127 and the pixel beside it on the minor axis at coverage 0.
// Each following tick item delivers the two pixels of the next interior column, with
// coverage 255 minus the top eight fraction bits of the crossing and that fraction.
// The last flag marks the final pixel of the whole line; a tick with no line in
// progress is taken and produces nothing, and a start item abandons any running line.
// One item is worked on at a time, driven by a microcoded sequencer that takes one
// step per cycle unless an emit step waits for the output. A start item is taken, its
// endpoints are sorted by the swap, order and prep steps, the restoring divider gives
// one quotient bit per cycle, the slope step forms the gradient and first crossing,
// and four emit steps hand out the endpoint pixels. A tick is taken and then handed
// out by one emit step for each pixel, as the single output register holds one result
// item at a time. Back-pressure on the output holds the sequencer at an emit step until
// the output register is free.
module antialiased_line_generator_top #(
  parameter int FRAC_BITS = awl_pkg::DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  awl_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output awl_pkg::out_item_t out_data
);

  localparam int C       = awl_pkg::COORD_BITS;
  localparam int P       = awl_pkg::PIX_BITS;
  localparam int CROSS_W = P + FRAC_BITS;
  localparam int QW      = FRAC_BITS + 1;
  localparam int REM_W   = C + 1;
  localparam int CNT_W   = $clog2(FRAC_BITS + 1);

  localparam logic [QW-1:0]      Q_ONE    = QW'(1) << FRAC_BITS;
  localparam logic [CROSS_W-1:0] FIX_ONE  = CROSS_W'(1) << FRAC_BITS;
  localparam logic [CNT_W-1:0]   CNT_LAST = CNT_W'(FRAC_BITS);

  awl_pkg::ctrl_t     ctrl;
  awl_pkg::seq_stat_t stat;

  // Captured item and endpoint registers (major/minor axis once swapped).
  awl_pkg::in_item_t  item_r;
  logic               steep_r;
  logic [C-1:0]       maj_a_r, min_a_r, maj_b_r, min_b_r;
  logic [C-1:0]       dx_r;
  logic               neg_r;

  // Divider.
  logic [REM_W-1:0]   rem_r;
  logic [QW-1:0]      q_r;
  logic [CNT_W-1:0]   cnt_r;

  // Line walk state.
  logic               active_r;
  logic [P-1:0]       column_r;
  logic [C-1:0]       col_end_r;
  logic [CROSS_W-1:0] crossing_r;
  logic [CROSS_W-1:0] slope_r;

  // Output register.
  logic               out_valid_r;
  awl_pkg::out_item_t out_data_r;

  // Combinational helpers.
  logic               take;
  logic               out_free;
  logic [C-1:0]       adx, ady;
  logic               steep;
  logic               div_ge;
  logic [REM_W-1:0]   div_diff;
  logic [QW-1:0]      slope_mag;
  logic [CROSS_W-1:0] mag_ext;
  logic [CROSS_W-1:0] cross_base;
  logic [P-1:0]       ip;
  logic [P-1:0]       ip_inc;
  logic [7:0]         frac;
  logic               fin;
  logic [P-1:0]       px_major, px_minor;
  logic [7:0]         px_cov;
  logic               px_last;
  awl_pkg::out_item_t pix_w;

  assign take     = in_valid && ctrl.take;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !ctrl.take;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    stat.in_valid = in_valid;
    stat.in_tick  = (in_data.kind == awl_pkg::KIND_TICK);
    stat.active   = active_r;
    stat.div_done = (cnt_r == CNT_LAST);
    stat.out_free = out_free;
  end

  awl_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // Steepness test on the captured endpoints.
  always_comb begin
    adx   = (item_r.start_x > item_r.end_x) ? item_r.start_x - item_r.end_x
                                            : item_r.end_x - item_r.start_x;
    ady   = (item_r.start_y > item_r.end_y) ? item_r.start_y - item_r.end_y
                                            : item_r.end_y - item_r.start_y;
    steep = ady > adx;
  end

  // One restoring division step: the divisor is subtracted when the remainder is not below it.
  always_comb begin
    div_ge   = rem_r >= {1'b0, dx_r};
    div_diff = div_ge ? rem_r - {1'b0, dx_r} : rem_r;
  end

  // Gradient and first crossing.
  always_comb begin
    slope_mag  = (dx_r == '0) ? Q_ONE : q_r;
    mag_ext    = {{(CROSS_W - QW){1'b0}}, slope_mag};
    cross_base = {1'b0, min_a_r, {FRAC_BITS{1'b0}}};
  end

  // Interior column pixel terms.
  always_comb begin
    ip     = crossing_r[FRAC_BITS +: P];
    ip_inc = ip + P'(1);
    frac   = crossing_r[FRAC_BITS-1 -: 8];
    fin    = ({1'b0, column_r} + (P + 1)'(1)) >= {2'b0, col_end_r};
  end

  // Pixel selection for the current emit step.
  always_comb begin
    px_major = '0;
    px_minor = '0;
    px_cov   = awl_pkg::COV_NONE;
    px_last  = 1'b0;
    unique case (ctrl.pix)
      awl_pkg::PIX_A0: begin
        px_major = {1'b0, maj_a_r};
        px_minor = {1'b0, min_a_r};
        px_cov   = awl_pkg::COV_HALF;
      end
      awl_pkg::PIX_A1: begin
        px_major = {1'b0, maj_a_r};
        px_minor = {1'b0, min_a_r} + P'(1);
      end
      awl_pkg::PIX_B0: begin
        px_major = {1'b0, maj_b_r};
        px_minor = {1'b0, min_b_r};
        px_cov   = awl_pkg::COV_HALF;
      end
      awl_pkg::PIX_B1: begin
        px_major = {1'b0, maj_b_r};
        px_minor = {1'b0, min_b_r} + P'(1);
        px_last  = !active_r;
      end
      awl_pkg::PIX_C0: begin
        px_major = column_r;
        px_minor = ip;
        px_cov   = awl_pkg::COV_FULL - frac;
      end
      awl_pkg::PIX_C1: begin
        px_major = column_r;
        px_minor = ip_inc;
        px_cov   = frac;
        px_last  = fin;
      end
      default: begin
        px_last = 1'b0;
      end
    endcase
    pix_w.pixel_x  = steep_r ? px_minor : px_major;
    pix_w.pixel_y  = steep_r ? px_major : px_minor;
    pix_w.coverage = px_cov;
    pix_w.last     = px_last;
  end

  // Datapath payload registers.
  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_data;
    end
    if (ctrl.fire) begin
      unique case (ctrl.op)
        awl_pkg::OP_SWAP: begin
          steep_r <= steep;
          if (steep) begin
            maj_a_r <= item_r.start_y;
            min_a_r <= item_r.start_x;
            maj_b_r <= item_r.end_y;
            min_b_r <= item_r.end_x;
          end else begin
            maj_a_r <= item_r.start_x;
            min_a_r <= item_r.start_y;
            maj_b_r <= item_r.end_x;
            min_b_r <= item_r.end_y;
          end
        end
        awl_pkg::OP_ORDER: begin
          if (maj_a_r > maj_b_r) begin
            maj_a_r <= maj_b_r;
            min_a_r <= min_b_r;
            maj_b_r <= maj_a_r;
            min_b_r <= min_a_r;
          end
        end
        awl_pkg::OP_PREP: begin
          dx_r  <= maj_b_r - maj_a_r;
          neg_r <= min_b_r < min_a_r;
          rem_r <= {1'b0, (min_b_r < min_a_r) ? min_a_r - min_b_r : min_b_r - min_a_r};
          q_r   <= '0;
          cnt_r <= '0;
        end
        awl_pkg::OP_DIV: begin
          rem_r <= {div_diff[REM_W-2:0], 1'b0};
          q_r   <= {q_r[QW-2:0], div_ge};
          cnt_r <= cnt_r + CNT_W'(1);
        end
        awl_pkg::OP_SLOPE: begin
          slope_r    <= neg_r ? CROSS_W'(0) - mag_ext : mag_ext;
          crossing_r <= neg_r ? cross_base - mag_ext : cross_base + mag_ext;
          column_r   <= {1'b0, maj_a_r} + P'(1);
          col_end_r  <= maj_b_r;
        end
        awl_pkg::OP_ADVANCE: begin
          crossing_r <= crossing_r + slope_r;
          column_r   <= column_r + P'(1);
        end
        default: begin
        end
      endcase
    end
    if (ctrl.emit && ctrl.fire) begin
      out_data_r <= pix_w;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.fire && ctrl.op == awl_pkg::OP_SLOPE) begin
        active_r <= dx_r >= C'(2);
      end else if (ctrl.fire && ctrl.op == awl_pkg::OP_ADVANCE && fin) begin
        active_r <= 1'b0;
      end
      if (ctrl.emit && ctrl.fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Once the final pixel of a line is handed to the output register, no line is active.
  assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.emit && ctrl.fire && pix_w.last) |=> !active_r)
    else $error("line still active after its final pixel");

  // A tick taken while a line runs goes straight to the first column pixel.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.kind == awl_pkg::KIND_TICK && active_r)
      |=> (ctrl.emit && ctrl.pix == awl_pkg::PIX_C0))
    else $error("tick on an active line did not start a column");

  // The gradient of a running line never exceeds one in magnitude.
  assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> ((slope_r[CROSS_W-1] ? CROSS_W'(0) - slope_r : slope_r) <= FIX_ONE))
    else $error("gradient magnitude above one");

endmodule

[src/awl_seq.sv]
// Microcode sequencer: step counter, control store lookup and jump logic.
module awl_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  awl_pkg::seq_stat_t  stat,
  output awl_pkg::ctrl_t      ctrl
);

  awl_pkg::step_t  step_r;
  awl_pkg::step_t  step_nxt;
  awl_pkg::step_t  step_inc;
  awl_pkg::ucode_t uw;
  logic            fire;

  assign uw       = awl_pkg::ucode_rom(step_r);
  assign fire     = !uw.emit || stat.out_free;
  assign step_inc = awl_pkg::step_t'(step_r + 4'd1);

  // Next step.
  always_comb begin
    step_nxt = step_r;
    unique case (uw.cond)
      awl_pkg::COND_NEXT: begin
        if (fire) step_nxt = step_inc;
      end
      awl_pkg::COND_GOTO: begin
        if (fire) step_nxt = uw.target;
      end
      awl_pkg::COND_LOOP: begin
        if (stat.div_done) step_nxt = step_inc;
      end
      awl_pkg::COND_DISPATCH: begin
        priority if (!stat.in_valid) begin
          step_nxt = step_r;
        end else if (stat.in_tick) begin
          step_nxt = stat.active ? awl_pkg::ST_COL0 : awl_pkg::ST_IDLE;
        end else begin
          step_nxt = awl_pkg::ST_SWAP;
        end
      end
      default: step_nxt = awl_pkg::ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    ctrl.op   = uw.op;
    ctrl.pix  = uw.pix;
    ctrl.emit = uw.emit;
    ctrl.take = uw.take;
    ctrl.fire = fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= awl_pkg::ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

[test/testbench.sv]
// Self-checking testbench for the antialiased line generator, with its own line predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Fixed-point layout of the predictor. The crossing carries the full pixel row plus the
  // fraction and a sign bit, and the gradient never exceeds 1.0 in magnitude.
  localparam int FRAC          = awl_pkg::DEF_FRAC_BITS;
  localparam int CROSS_BITS    = awl_pkg::PIX_BITS + FRAC + 1;
  localparam int GRAD_BITS     = FRAC + 2;
  localparam int COORD_MAX     = (1 << awl_pkg::COORD_BITS) - 1;
  localparam int ITEM_BITS     = $bits(awl_pkg::in_item_t);
  localparam int LINE_ITEMS    = 180;
  // Twice the time that a start item keeps the block busy is a comfortable margin for
  // anything still in flight once the last pixel has arrived.
  localparam int SETTLE_CYCLES = 2 * (FRAC + 10);
  localparam int DRAIN_LIMIT   = 50000;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  awl_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  awl_pkg::out_item_t out_data;

  // Items waiting to be offered, and pixels that the predictor says must come out next.
  awl_pkg::in_item_t  line_items[$];
  awl_pkg::out_item_t pending_pixels[$];

  int mismatches = 0;
  bit item_taken = 1'b0;
  int burst_left = 0;
  int gap_left   = 0;
  int stall_left = 0;
  int free_left  = 0;

  // The predictor's own copy of the line in progress.
  bit                             line_active = 1'b0;
  bit                             line_steep  = 1'b0;
  logic [awl_pkg::PIX_BITS-1:0]   cur_column  = '0;
  logic [awl_pkg::COORD_BITS-1:0] end_column  = '0;
  logic [CROSS_BITS-1:0]          cross_acc   = '0;
  logic [GRAD_BITS-1:0]           grad        = '0;

  always #10 clk = ~clk;

  antialiased_line_generator_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Prints one line per mismatch and counts every one of them.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Queues one pixel, placing the major and minor coordinates according to steepness.
  task automatic emit_pixel(input logic [awl_pkg::PIX_BITS-1:0] major,
                            input logic [awl_pkg::PIX_BITS-1:0] minor,
                            input logic [awl_pkg::COV_BITS-1:0] cov, input logic last);
    awl_pkg::out_item_t px;
    px.pixel_x  = line_steep ? minor : major;
    px.pixel_y  = line_steep ? major : minor;
    px.coverage = cov;
    px.last     = last;
    pending_pixels.push_back(px);
  endtask

  // Works out the pixels that one accepted item must produce and updates the line state.
  task automatic draw_item(input awl_pkg::in_item_t it);
    logic [awl_pkg::COORD_BITS-1:0] ax, ay, bx, by, swap_tmp, adx, ady, dx, mag;
    logic [31:0]                    quot;
    logic [awl_pkg::PIX_BITS-1:0]   row;
    logic [awl_pkg::COV_BITS-1:0]   frac;
    bit                             closing;
    if (it.kind == awl_pkg::KIND_START) begin
      ax  = it.start_x;
      ay  = it.start_y;
      bx  = it.end_x;
      by  = it.end_y;
      adx = (ax > bx) ? ax - bx : bx - ax;
      ady = (ay > by) ? ay - by : by - ay;
      line_steep = ady > adx;
      // A steep line is walked along y, so the axes trade places.
      if (line_steep) begin
        swap_tmp = ax; ax = ay; ay = swap_tmp;
        swap_tmp = bx; bx = by; by = swap_tmp;
      end
      if (ax > bx) begin
        swap_tmp = ax; ax = bx; bx = swap_tmp;
        swap_tmp = ay; ay = by; by = swap_tmp;
      end
      dx  = bx - ax;
      mag = (by < ay) ? ay - by : by - ay;
      // A single-point line gets a gradient of exactly one; otherwise the quotient is
      // truncated towards zero and the sign applied afterwards.
      if (dx == 0) begin
        grad = GRAD_BITS'(1) << FRAC;
      end else begin
        quot = (32'(mag) << FRAC) / 32'(dx);
        grad = (by < ay) ? GRAD_BITS'(-quot) : GRAD_BITS'(quot);
      end
      cross_acc   = (CROSS_BITS'(ay) << FRAC) + CROSS_BITS'(signed'(grad));
      cur_column  = awl_pkg::PIX_BITS'(ax) + 1'b1;
      end_column  = bx;
      line_active = dx >= 2;
      emit_pixel(awl_pkg::PIX_BITS'(ax), awl_pkg::PIX_BITS'(ay), awl_pkg::COV_HALF, 1'b0);
      emit_pixel(awl_pkg::PIX_BITS'(ax), awl_pkg::PIX_BITS'(ay) + 1'b1,
                 awl_pkg::COV_NONE, 1'b0);
      emit_pixel(awl_pkg::PIX_BITS'(bx), awl_pkg::PIX_BITS'(by), awl_pkg::COV_HALF, 1'b0);
      emit_pixel(awl_pkg::PIX_BITS'(bx), awl_pkg::PIX_BITS'(by) + 1'b1,
                 awl_pkg::COV_NONE, !line_active);
    end else if (line_active) begin
      row       = cross_acc[FRAC +: awl_pkg::PIX_BITS];
      frac      = cross_acc[FRAC-awl_pkg::COV_BITS +: awl_pkg::COV_BITS];
      cross_acc = cross_acc + CROSS_BITS'(signed'(grad));
      closing   = int'(cur_column) + 1 >= int'(end_column);
      emit_pixel(cur_column, row, awl_pkg::COV_FULL - frac, 1'b0);
      emit_pixel(cur_column, row + 1'b1, frac, closing);
      cur_column = cur_column + 1'b1;
      if (closing) begin
        line_active = 1'b0;
      end
    end
  endtask

  // A tick item with random rubbish in the endpoint fields, which the block must ignore.
  function automatic awl_pkg::in_item_t tick_item();
    awl_pkg::in_item_t    it;
    logic [ITEM_BITS-1:0] raw;
    raw     = ITEM_BITS'({$urandom, $urandom});
    it      = raw;
    it.kind = awl_pkg::KIND_TICK;
    return it;
  endfunction

  // Queues a start item for the given endpoints followed by a number of tick items.
  task automatic queue_line(input int x0, input int y0, input int x1, input int y1,
                            input int ticks);
    awl_pkg::in_item_t it;
    it.kind    = awl_pkg::KIND_START;
    it.start_x = awl_pkg::COORD_BITS'(x0);
    it.start_y = awl_pkg::COORD_BITS'(y0);
    it.end_x   = awl_pkg::COORD_BITS'(x1);
    it.end_y   = awl_pkg::COORD_BITS'(y1);
    line_items.push_back(it);
    repeat (ticks) line_items.push_back(tick_item());
  endtask

  // Stimulus and end of run. The directed lines come first, then random lines that are
  // mostly drawn to their end so that the column walk and the last flag are exercised
  // often, with the odd one abandoned part-way by the next start.
  initial begin : stimulus
    int x0, y0, x1, y1, span, interior, ticks, counted, waited;
    // A tick with no line in progress must produce nothing.
    line_items.push_back(tick_item());
    // A single-point line, then a tick that finds the block idle again.
    queue_line(5, 5, 5, 5, 1);
    // A line of length one has no interior columns.
    queue_line(10, 10, 11, 10, 0);
    // A short shallow line walked to its end, plus one surplus tick.
    queue_line(3, 7, 8, 9, 5);
    // A steep line given from its far end, abandoned after two columns.
    queue_line(4095, 4095, 4090, 0, 2);
    // An exact diagonal across the whole range: not steep, gradient of minus one.
    queue_line(4095, 0, 0, 4095, 2);
    // A vertical line.
    queue_line(100, 0, 100, 3, 2);
    // A shallow falling line on the top row, so the pixel below reaches 4096.
    queue_line(0, 4095, 4095, 4000, 1);
    // A short steep line given in reverse order, walked to its end.
    queue_line(20, 30, 17, 26, 3);

    // Every queued item counts towards the total, surplus ticks included.
    counted = line_items.size();
    while (counted < LINE_ITEMS) begin
      x0 = $urandom_range(0, COORD_MAX);
      y0 = $urandom_range(0, COORD_MAX);
      if ($urandom_range(0, 4) == 0) begin
        x1 = $urandom_range(0, COORD_MAX);
        y1 = $urandom_range(0, COORD_MAX);
      end else begin
        x1 = x0 + int'($urandom_range(0, 20)) - 10;
        y1 = y0 + int'($urandom_range(0, 20)) - 10;
        x1 = (x1 < 0) ? 0 : (x1 > COORD_MAX) ? COORD_MAX : x1;
        y1 = (y1 < 0) ? 0 : (y1 > COORD_MAX) ? COORD_MAX : y1;
      end
      span = (x1 > x0) ? x1 - x0 : x0 - x1;
      if (((y1 > y0) ? y1 - y0 : y0 - y1) > span) begin
        span = (y1 > y0) ? y1 - y0 : y0 - y1;
      end
      interior = (span >= 2) ? span - 1 : 0;
      if (interior <= 40 && $urandom_range(0, 3) != 0) begin
        ticks = interior + $urandom_range(0, 2);
      end else begin
        ticks = $urandom_range(0, (interior < 12) ? interior : 12);
      end
      counted += 1 + ticks;
      queue_line(x0, y0, x1, y1, ticks);
    end

    repeat (7) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // Wait for the last item to be taken, then for every predicted pixel to arrive.
    while (line_items.size() != 0 || in_valid) @(posedge clk);
    waited = 0;
    while (pending_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_pixels.size() != 0) begin
      report_mismatch("pixels never delivered", 0, pending_pixels.size());
    end
    // Let the block settle so that any stray pixel after the last one is caught.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS antialiased_line_generator_top");
    end else begin
      $display("FAIL antialiased_line_generator_top");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #5_000_000;
    $display("FAIL antialiased_line_generator_top");
    $finish;
  end

  // Sender: offers items in bursts of random length, separated by gaps of random length
  // so that idle cycles land during the division as well as during pixel output. A
  // stalled item is held unchanged until it has been taken.
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !item_taken)) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (line_items.size() != 0) begin
        in_data  <= line_items.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          case ($urandom_range(0, 3))
            0:       gap_left = 0;
            1:       gap_left = $urandom_range(1, 3);
            2:       gap_left = $urandom_range(4, 12);
            default: gap_left = $urandom_range(13, 40);
          endcase
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: alternates runs of stall with free runs, some of them long enough to let
  // the block stream without any back-pressure at all.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (free_left != 0) begin
      out_stall <= 1'b0;
      free_left--;
    end else begin
      out_stall  <= 1'b0;
      stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      free_left  = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    end
  end

  // Monitor: at each rising edge, an accepted input item is run through the predictor and
  // an accepted pixel is compared field by field with the oldest expected one.
  always @(posedge clk) begin : monitor
    awl_pkg::out_item_t want;
    if (!rst_n) begin
      item_taken = 1'b0;
    end else begin
      item_taken = in_valid && !in_stall;
      if (item_taken) begin
        draw_item(in_data);
      end
      if (out_valid && !out_stall) begin
        if (pending_pixels.size() == 0) begin
          report_mismatch("pixel with nothing expected, pixel_x", 32'(out_data.pixel_x), 0);
        end else begin
          want = pending_pixels.pop_front();
          if (out_data.pixel_x !== want.pixel_x) begin
            report_mismatch("pixel_x", 32'(out_data.pixel_x), 32'(want.pixel_x));
          end
          if (out_data.pixel_y !== want.pixel_y) begin
            report_mismatch("pixel_y", 32'(out_data.pixel_y), 32'(want.pixel_y));
          end
          if (out_data.coverage !== want.coverage) begin
            report_mismatch("coverage", 32'(out_data.coverage), 32'(want.coverage));
          end
          if (out_data.last !== want.last) begin
            report_mismatch("last", 32'(out_data.last), 32'(want.last));
          end
        end
      end
    end
  end

endmodule

[files.f]
src/awl_pkg.sv
src/awl_seq.sv
src/antialiased_line_generator_top.sv
test/testbench.sv
